/* rtl/p1_telegram_crc_framer_assert.svh */
// assertion macros for the p1 telegram framer
// no dependencies; included by modules that check their own logic
`ifndef P1_TELEGRAM_CRC_FRAMER_ASSERT_SVH
`define P1_TELEGRAM_CRC_FRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define P1TCF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("p1tcf assertion failed");
`define P1TCF_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("p1tcf forbidden condition");
`else
`define P1TCF_ASSERT(lbl, clk, rst, prop)
`define P1TCF_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/p1tcf_pkg.sv */
// types, constants and functions shared by the p1 telegram framer
// no dependencies
package p1tcf_pkg;

  localparam int MAX_TELEGRAM = 2048;
  localparam int LOG_W = $clog2(MAX_TELEGRAM);
  localparam int POS_W = LOG_W + 1;
  localparam int ADDR_W = LOG_W + 1;
  localparam int MEM_DEPTH = 2 * MAX_TELEGRAM;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PW = $clog2(CMD_DEPTH);
  localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH = 4;
  localparam int RES_PW = $clog2(RES_DEPTH);
  localparam int RES_CW = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [2:0] HEX_DIGITS = 3'd4;
  localparam logic [15:0] POLY_RESET = 16'hA001;

  typedef enum logic [2:0] {
    EV_GOOD = 3'd0,
    EV_CRC_ERR = 3'd1,
    EV_OVERFLOW = 3'd2,
    EV_RESTART = 3'd3,
    EV_READ = 3'd4,
    EV_RANGE = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_BODY = 3'b010,
    PH_SUM = 3'b100
  } phase_t;

  typedef struct packed {
    event_t ev;
    logic [11:0] length;
    logic [7:0] tag;
    logic [15:0] err_count;
    logic [15:0] crc;
    logic [15:0] sum;
  } res_t;

  typedef struct packed {
    res_t res;
    logic [7:0] read_byte;
  } out_t;

  typedef struct packed {
    logic wr_en;
    logic crlf;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0] wr_data;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic res_en;
    res_t res;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  // bit 4 set for a valid hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'h00;
  endfunction

endpackage

/* rtl/p1tcf_front.sv */
// front part: frame state, crc, checksum parse and command build per item
// depends on p1tcf_pkg
module p1tcf_front import p1tcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [10:0] read_index,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        cmd_push,
  output cmd_t        cmd
);

  phase_t phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0] crc, crc_next;
  logic [2:0] cnt, cnt_next;
  logic [15:0] acc, acc_next;
  logic inv, inv_next;
  logic bank, bank_next;
  logic [11:0] plen, plen_next;
  logic [7:0] tag, tag_next;
  logic [15:0] errc, errc_next;
  logic [15:0] poly;
  logic [4:0] nib;
  event_t ev;

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    crc_next = crc;
    cnt_next = cnt;
    acc_next = acc;
    inv_next = inv;
    bank_next = bank;
    plen_next = plen;
    tag_next = tag;
    errc_next = errc;
    nib = hex_nibble(rx_byte);
    ev = EV_GOOD;
    cmd = '0;
    cmd.wr_addr = {~bank, pos[LOG_W-1:0]};
    cmd.wr_data = rx_byte;
    cmd.rd_addr = {bank, LOG_W'(read_index)};
    if (req_type) begin
      cmd.res_en = 1'b1;
      if ({1'b0, read_index} < plen) begin
        ev = EV_READ;
        cmd.rd_en = 1'b1;
      end else begin
        ev = EV_RANGE;
      end
    end else if (rx_byte == CH_SLASH) begin
      cmd.wr_en = 1'b1;
      cmd.wr_addr = {~bank, LOG_W'(0)};
      pos_next = POS_W'(1);
      crc_next = crc_byte(16'h0000, rx_byte, poly);
      phase_next = PH_BODY;
      if (phase == PH_BODY) begin
        cmd.res_en = 1'b1;
        ev = EV_RESTART;
      end
    end else if (phase == PH_WAIT) begin
      cmd.res_en = 1'b0;
    end else if (pos >= POS_W'(MAX_TELEGRAM)) begin
      pos_next = '0;
      phase_next = PH_WAIT;
      cmd.res_en = 1'b1;
      ev = EV_OVERFLOW;
    end else if (phase == PH_BODY) begin
      cmd.wr_en = 1'b1;
      pos_next = pos + 1'b1;
      crc_next = crc_byte(crc, rx_byte, poly);
      if (rx_byte == CH_BANG) begin
        cnt_next = '0;
        acc_next = '0;
        inv_next = 1'b0;
        phase_next = PH_SUM;
      end
    end else if (cnt < HEX_DIGITS) begin
      cmd.wr_en = 1'b1;
      pos_next = pos + 1'b1;
      acc_next = {acc[11:0], nib[3:0]};
      inv_next = inv | ~nib[4];
      cnt_next = cnt + 1'b1;
    end else begin
      phase_next = PH_WAIT;
      cmd.res_en = 1'b1;
      if (pos > POS_W'(MAX_TELEGRAM - 2)) begin
        pos_next = '0;
        ev = EV_OVERFLOW;
      end else begin
        cmd.wr_en = 1'b1;
        cmd.crlf = 1'b1;
        pos_next = pos + POS_W'(2);
        if (!inv && crc == acc) begin
          bank_next = ~bank;
          plen_next = 12'(pos_next);
          tag_next = tag + 1'b1;
          ev = EV_GOOD;
        end else begin
          errc_next = errc + 1'b1;
          ev = EV_CRC_ERR;
        end
      end
    end
    cmd.res.ev = ev;
    cmd.res.length = req_type ? plen : plen_next;
    cmd.res.tag = req_type ? tag : tag_next;
    cmd.res.err_count = req_type ? errc : errc_next;
    cmd.res.crc = req_type ? crc : crc_next;
    cmd.res.sum = req_type ? acc : acc_next;
    cmd_push = accept && (cmd.wr_en || cmd.res_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      pos <= '0;
      crc <= '0;
      cnt <= '0;
      acc <= '0;
      inv <= 1'b0;
      bank <= 1'b0;
      plen <= '0;
      tag <= '0;
      errc <= '0;
      poly <= POLY_RESET;
    end else begin
      if (cfg_we) begin
        poly <= cfg_data;
      end
      if (accept && !req_type) begin
        phase <= phase_next;
        pos <= pos_next;
        crc <= crc_next;
        cnt <= cnt_next;
        acc <= acc_next;
        inv <= inv_next;
        bank <= bank_next;
        plen <= plen_next;
        tag <= tag_next;
        errc <= errc_next;
      end
    end
  end

endmodule

/* rtl/p1tcf_cmd_q.sv */
// command queue between front and back parts
// depends on p1tcf_pkg
module p1tcf_cmd_q import p1tcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t q [CMD_DEPTH];
  logic [CMD_PW-1:0] rd_ptr, wr_ptr;
  logic [CMD_CW-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CMD_CW'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CMD_CW'(do_push) - CMD_CW'(do_pop);
    end
  end

endmodule

/* rtl/p1tcf_back.sv */
// back part: frame store writes and reads, result staging and result queue
// depends on p1tcf_pkg and the assertion macro header
`include "p1_telegram_crc_framer_assert.svh"
module p1tcf_back import p1tcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head,
  output logic head_pop,
  input  logic pop,
  output logic empty,
  output out_t out
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata;
  logic half;
  logic pend_valid;
  res_t pend_res;
  out_t res_q [RES_DEPTH];
  logic [RES_PW-1:0] rd_ptr, wr_ptr;
  logic [RES_CW-1:0] count;
  logic issue, we, re, do_pop;
  logic [ADDR_W-1:0] waddr;
  logic [7:0] wdata;

  assign issue = head_valid && ((count + RES_CW'(pend_valid)) <= RES_CW'(RES_DEPTH - 2));
  assign head_pop = issue && !(head.crlf && !half);
  assign re = head_pop && head.rd_en;

  always_comb begin
    we = issue && head.wr_en;
    waddr = head.wr_addr;
    wdata = head.wr_data;
    if (head.crlf) begin
      if (half) begin
        waddr = head.wr_addr + 1'b1;
        wdata = CH_LF;
      end else begin
        wdata = CH_CR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[head.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      pend_res <= head.res;
    end
    if (pend_valid) begin
      res_q[wr_ptr].res <= pend_res;
      res_q[wr_ptr].read_byte <= (pend_res.ev == EV_READ) ? rdata : 8'h00;
    end
  end

  assign empty = (count == '0);
  assign out = res_q[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
      pend_valid <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (issue) begin
        half <= head.crlf && !half;
      end
      pend_valid <= head_pop && head.res_en;
      if (pend_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RES_CW'(pend_valid) - RES_CW'(do_pop);
    end
  end

  `P1TCF_ASSERT(a_count_bound, clk, rst, count <= RES_CW'(RES_DEPTH))
  `P1TCF_ASSERT(a_half_on_crlf, clk, rst, half |-> (head_valid && head.crlf))
  `P1TCF_ASSERT(a_room_for_pend, clk, rst, pend_valid |-> (count < RES_CW'(RES_DEPTH)))

endmodule

/* rtl/p1_telegram_crc_framer.sv */
// p1 telegram framer with crc-16 check, top level
// path: a result passes the command queue, pending register and result queue
// throughput: one item per cycle while the queues have room; a good or bad close
// holds the back part for a second store write (cr then lf, single write port)
// reset: synchronous active-high rst clears all control state; the frame store
// holds no reset value and needs no clearing pass
module p1_telegram_crc_framer import p1tcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [10:0] read_index,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res,
  output logic [11:0] telegram_length,
  output logic [7:0]  telegram_tag,
  output logic [15:0] crc_error_count,
  output logic [15:0] computed_crc,
  output logic [15:0] received_crc,
  output logic [7:0]  read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t cmd, head;
  logic cmd_push, head_valid, head_pop, accept;
  out_t out;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  p1tcf_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .req_type(req_type), .rx_byte(rx_byte),
    .read_index(read_index), .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .cmd_push(cmd_push), .cmd(cmd)
  );

  p1tcf_cmd_q u_cmd_q (
    .clk(clk), .rst(rst), .push(cmd_push), .push_data(cmd), .full(full),
    .pop(head_pop), .head_valid(head_valid), .head(head)
  );

  p1tcf_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .head_pop(head_pop),
    .pop(pop), .empty(empty), .out(out)
  );

  assign event_res = out.res.ev;
  assign telegram_length = out.res.length;
  assign telegram_tag = out.res.tag;
  assign crc_error_count = out.res.err_count;
  assign computed_crc = out.res.crc;
  assign received_crc = out.res.sum;
  assign read_byte = out.read_byte;

endmodule
